// ===== hw/rtl/isc_pkg.sv =====
// ----------------------------------------------------------------------------
// isc_pkg
// Shared types, register map offsets and codes of the interrupt source
// controller.
// ----------------------------------------------------------------------------
package isc_pkg;

   // default sizes
   localparam int DEF_NUM_SOURCES = 63;
   localparam int DEF_NUM_HARTS   = 4;

   // stream payload widths
   localparam int REQ_TDATA_W = 80;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 40;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_BASE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE = 1'b1;
   localparam logic [15:0] WINDOW_SIZE_RESET = 16'h8000;

   // register map
   localparam logic [31:0] OFS_DOMAINCFG     = 32'h0000_0000;
   localparam logic [31:0] OFS_SRCCFG_FIRST  = 32'h0000_0004;
   localparam logic [31:0] OFS_SET_ENABLE    = 32'h0000_1edc;
   localparam logic [31:0] OFS_CLR_ENABLE    = 32'h0000_1fdc;
   localparam logic [31:0] OFS_TARGET_FIRST  = 32'h0000_3004;
   localparam logic [31:0] OFS_HART_BASE     = 32'h0000_4000;
   localparam int          HART_STRIDE       = 32;
   localparam int          HART_REG_W        = 5;

   localparam logic [HART_REG_W-1:0] HART_OFS_IDELIVERY  = 5'h00;
   localparam logic [HART_REG_W-1:0] HART_OFS_IFORCE     = 5'h04;
   localparam logic [HART_REG_W-1:0] HART_OFS_ITHRESHOLD = 5'h08;
   localparam logic [HART_REG_W-1:0] HART_OFS_TOPI       = 5'h18;
   localparam logic [HART_REG_W-1:0] HART_OFS_CLAIMI     = 5'h1c;

   // bits of the domain and source configuration words
   localparam int          DOMAIN_IE_BIT      = 8;
   localparam int          SRC_DELEGATE_BIT   = 10;
   localparam int          SRC_MODE_W         = 3;
   localparam logic [SRC_MODE_W-1:0] SRC_MODE_EDGE_RISE = 3'd4;

   // claim scan
   localparam int SCAN_W         = 16;
   localparam int SCAN_POS_W     = 4;
   localparam int ID_W           = 10;
   localparam int CLAIM_ID_SHIFT = 16;

   typedef enum logic [1:0] {
      KIND_READ  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_EVENT = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_OUTSIDE     = 3'd1,
      ST_CLAIM_WRITE = 3'd2,
      ST_CLAIM_NONE  = 3'd3,
      ST_UNKNOWN     = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      RC_DOMAIN,
      RC_SRCCFG,
      RC_TARGET,
      RC_HART_ZERO,
      RC_CLAIM,
      RC_SET_EN,
      RC_CLR_EN,
      RC_UNKNOWN
   } reg_class_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_CHECK,
      S_DECODE,
      S_MEM,
      S_SCAN,
      S_DONE
   } state_type;

   typedef struct packed {
      logic done;
      logic found;
   } scan_res_type;

endpackage

// ===== hw/rtl/isc_ram.sv =====
// ----------------------------------------------------------------------------
// isc_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module isc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                       wr_data,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/isc_reg_decode.sv =====
// ----------------------------------------------------------------------------
// isc_reg_decode
// Classifies a window offset into a register class and, for the source
// configuration words, the entry index.
// ----------------------------------------------------------------------------
module isc_reg_decode
   import isc_pkg::*;
#(
   parameter int NUM_SOURCES = DEF_NUM_SOURCES,
   parameter int NUM_HARTS   = DEF_NUM_HARTS
) (
   input  logic [31:0]                                         ofs,
   output reg_class_type                                       cls,
   output logic [((NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1)-1:0] cfg_idx
);

   localparam int IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
   localparam logic [31:0] LAST_SRC = OFS_SRCCFG_FIRST + 32'((NUM_SOURCES - 1) * 4);
   localparam logic [31:0] LAST_TGT = OFS_TARGET_FIRST + 32'((NUM_SOURCES - 1) * 4);
   localparam logic [31:0] HART_END = OFS_HART_BASE + 32'(NUM_HARTS * HART_STRIDE);

   logic [HART_REG_W-1:0] hart_reg;

   // hart base is stride aligned, so the low bits give the register
   assign hart_reg = ofs[HART_REG_W-1:0];
   assign cfg_idx  = ofs[IDX_W+1:2] - IDX_W'(1);

   always_comb begin
      cls = RC_UNKNOWN;
      if (ofs >= OFS_SRCCFG_FIRST && ofs <= LAST_SRC) begin
         cls = RC_SRCCFG;
      end else if (ofs >= OFS_TARGET_FIRST && ofs <= LAST_TGT) begin
         cls = RC_TARGET;
      end else if (ofs >= OFS_HART_BASE && ofs < HART_END) begin
         unique case (hart_reg) inside
            HART_OFS_IDELIVERY, HART_OFS_IFORCE, HART_OFS_ITHRESHOLD,
            HART_OFS_TOPI: begin
               cls = RC_HART_ZERO;
            end
            HART_OFS_CLAIMI: begin
               cls = RC_CLAIM;
            end
            default: begin
               cls = RC_UNKNOWN;
            end
         endcase
      end else if (ofs == OFS_DOMAINCFG) begin
         cls = RC_DOMAIN;
      end else if (ofs == OFS_SET_ENABLE) begin
         cls = RC_SET_EN;
      end else if (ofs == OFS_CLR_ENABLE) begin
         cls = RC_CLR_EN;
      end
   end

endmodule

// ===== hw/rtl/isc_claim_scan.sv =====
// ----------------------------------------------------------------------------
// isc_claim_scan
// Finds the lowest pending source, one chunk of pending bits per cycle.
// ----------------------------------------------------------------------------
module isc_claim_scan
   import isc_pkg::*;
#(
   parameter int NUM_SOURCES = DEF_NUM_SOURCES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [NUM_SOURCES-1:0] pending,
   output scan_res_type           res,
   output logic [ID_W-1:0]        id
);

   localparam int NCHUNK = (NUM_SOURCES + SCAN_W - 1) / SCAN_W;
   localparam int CNT_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
   localparam int PAD_W  = NCHUNK * SCAN_W;

   logic [PAD_W-1:0]      padded;
   logic [SCAN_W-1:0]     chunk;
   logic [SCAN_POS_W-1:0] pos;
   logic                  busy_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  last;

   assign padded = PAD_W'(pending);
   assign chunk  = padded[cnt_ff*SCAN_W +: SCAN_W];
   assign last   = (cnt_ff == CNT_W'(NCHUNK - 1));

   always_comb begin
      pos = '0;
      for (int i = SCAN_W - 1; i >= 0; i--) begin
         if (chunk[i]) begin
            pos = SCAN_POS_W'(i);
         end
      end
   end

   assign res.found = |chunk;
   assign res.done  = busy_ff && ((|chunk) || last);
   assign id        = ID_W'({cnt_ff, pos}) + ID_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         if (res.done) begin
            busy_ff <= 1'b0;
         end else begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
      end
   end

endmodule

// ===== hw/rtl/interrupt_source_controller.sv =====
// ----------------------------------------------------------------------------
// interrupt_source_controller
// Interrupt domain with per-source configuration words, enable and pending
// bits, reached by bus reads and writes and updated by wire level events.
// ----------------------------------------------------------------------------
// Usage: each req_ transfer carries one bus read, bus write or wire event
// (kind in req_tuser). Exactly one rsp_ transfer follows for each, carrying
// read data, status and the combined pending flag after the step.
// Items are handled one at a time: accept, window check, decode, then done.
// An access outside the window or an unused kind skips decode. A read of
// a source configuration word, or a wire event on a valid source while
// the domain is enabled, adds a configuration memory read step. A claim
// read adds a scan, in which the claim unit scans 16 pending bits a cycle
// and stops at the first chunk holding a pending bit.
// The output register holds a finished result while rsp_tready is low, and
// the next request is taken in the meantime; the block only waits when a
// second result is ready before the first has gone.
// Reset is synchronous and clears the control state, not the captured
// payload; after it the configuration memory is cleared one entry a cycle,
// and req_tready stays low until that is done. csr_ writes land at once
// and are meant for idle periods.
// ----------------------------------------------------------------------------
module interrupt_source_controller
   import isc_pkg::*;
#(
   parameter int NUM_SOURCES = DEF_NUM_SOURCES,
   parameter int NUM_HARTS   = DEF_NUM_HARTS
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // address[31:0], access_size[35:32], write_data[67:36], source[73:68],
   // level[74], zero fill above
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // kind[1:0]
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   // response channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // read_data[31:0], status[34:32], irq_pending[35], zero fill above
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // configuration write port
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

   state_type state_ff, state_in;

   // configuration registers
   logic [31:0] base_ff;
   logic [15:0] size_ff;

   // captured request
   kind_type    kind_ff;
   logic [31:0] addr_ff;
   logic [32:0] end_ff;
   logic [31:0] wdata_ff;
   logic [5:0]  src_ff;
   logic        level_ff;
   logic [31:0] ofs_ff;
   logic [31:0] rd_ff;
   status_type  st_ff;

   // domain state
   logic [NUM_SOURCES-1:0] pending_ff;
   logic [NUM_SOURCES-1:0] enable_ff;
   logic                   domain_en_ff;
   logic [IDX_W-1:0]       clr_cnt_ff;

   // output register
   logic        rsp_valid_ff;
   logic [31:0] rsp_rd_ff;
   status_type  rsp_st_ff;
   logic        rsp_irq_ff;

   // datapath
   logic             is_bus;
   logic             outside;
   logic             rsp_free;
   logic             src_ok;
   logic [31:0]      src_m1;
   logic [IDX_W-1:0] src_idx;
   logic [31:0]      wd_m1;
   logic             en_num_ok;
   logic             evt_take;
   reg_class_type    dec_cls;
   logic [IDX_W-1:0] cfg_idx;
   logic             ram_we;
   logic [IDX_W-1:0] ram_addr;
   logic [31:0]      ram_wdata;
   logic [31:0]      ram_rdata;
   logic             mem_rd;
   logic             scan_start;
   scan_res_type     scan_res;
   logic [ID_W-1:0]  scan_id;
   logic [ID_W-1:0]  claim_m1;

   isc_ram #(
      .WIDTH (32),
      .DEPTH (NUM_SOURCES)
   ) u_srccfg_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   isc_reg_decode #(
      .NUM_SOURCES (NUM_SOURCES),
      .NUM_HARTS   (NUM_HARTS)
   ) u_reg_decode (
      .ofs     (ofs_ff),
      .cls     (dec_cls),
      .cfg_idx (cfg_idx)
   );

   isc_claim_scan #(
      .NUM_SOURCES (NUM_SOURCES)
   ) u_claim_scan (
      .clock   (clock),
      .reset   (reset),
      .start   (scan_start),
      .pending (pending_ff),
      .res     (scan_res),
      .id      (scan_id)
   );

   assign is_bus    = (kind_ff == KIND_READ) || (kind_ff == KIND_WRITE);
   assign outside   = (addr_ff < base_ff) ||
                      (end_ff > ({1'b0, base_ff} + 33'(size_ff)));
   assign rsp_free  = !rsp_valid_ff || rsp_tready;
   assign src_m1    = 32'(src_ff) - 32'd1;
   assign src_idx   = src_m1[IDX_W-1:0];
   assign src_ok    = (src_ff != '0) && (32'(src_ff) <= 32'(NUM_SOURCES));
   assign wd_m1     = wdata_ff - 32'd1;
   assign en_num_ok = (wdata_ff != '0) && (wdata_ff <= 32'(NUM_SOURCES));
   assign claim_m1  = scan_id - ID_W'(1);
   // rising-edge mode and not delegated
   assign evt_take  = !ram_rdata[SRC_DELEGATE_BIT] &&
                      (ram_rdata[SRC_MODE_W-1:0] == SRC_MODE_EDGE_RISE);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_cnt_ff == IDX_W'(NUM_SOURCES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            case (kind_ff) inside
               KIND_READ, KIND_WRITE: begin
                  state_in = outside ? S_DONE : S_DECODE;
               end
               KIND_EVENT: begin
                  state_in = S_DECODE;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_DECODE: begin
            if (mem_rd) begin
               state_in = S_MEM;
            end else if (scan_start) begin
               state_in = S_SCAN;
            end else begin
               state_in = S_DONE;
            end
         end
         S_MEM: begin
            state_in = S_DONE;
         end
         S_SCAN: begin
            if (scan_res.done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      req_tready = 1'b0;
      ram_we     = 1'b0;
      ram_addr   = cfg_idx;
      ram_wdata  = wdata_ff;
      mem_rd     = 1'b0;
      scan_start = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_addr  = clr_cnt_ff;
            ram_wdata = '0;
         end
         S_IDLE: begin
            req_tready = 1'b1;
         end
         S_DECODE: begin
            if (kind_ff == KIND_EVENT) begin
               ram_addr = src_idx;
               mem_rd   = domain_en_ff && src_ok;
            end else if (is_bus) begin
               if (dec_cls == RC_SRCCFG) begin
                  if (kind_ff == KIND_WRITE) begin
                     ram_we = 1'b1;
                  end else begin
                     mem_rd = 1'b1;
                  end
               end else if (dec_cls == RC_CLAIM && kind_ff == KIND_READ) begin
                  scan_start = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         size_ff      <= WINDOW_SIZE_RESET;
         pending_ff   <= '0;
         enable_ff    <= '0;
         domain_en_ff <= 1'b0;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_WINDOW_BASE: base_ff <= csr_wdata;
               CSR_WINDOW_SIZE: size_ff <= csr_wdata[15:0];
               default: begin
               end
            endcase
         end
         if (state_ff == S_CLEAR) begin
            clr_cnt_ff <= clr_cnt_ff + IDX_W'(1);
         end
         if (state_ff == S_DECODE && kind_ff == KIND_WRITE) begin
            if (dec_cls == RC_DOMAIN) begin
               domain_en_ff <= wdata_ff[DOMAIN_IE_BIT];
            end
            if ((dec_cls == RC_SET_EN || dec_cls == RC_CLR_EN) && en_num_ok) begin
               enable_ff[wd_m1[IDX_W-1:0]] <= (dec_cls == RC_SET_EN);
            end
         end
         if (state_ff == S_MEM && kind_ff == KIND_EVENT && evt_take) begin
            pending_ff[src_idx] <= level_ff;
         end
         if (state_ff == S_SCAN && scan_res.done && scan_res.found) begin
            pending_ff[claim_m1[IDX_W-1:0]] <= 1'b0;
         end
         if (state_ff == S_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               kind_ff  <= kind_type'(req_tuser[1:0]);
               addr_ff  <= req_tdata[31:0];
               end_ff   <= {1'b0, req_tdata[31:0]} + 33'(req_tdata[35:32]);
               wdata_ff <= req_tdata[67:36];
               src_ff   <= req_tdata[73:68];
               level_ff <= req_tdata[74];
               rd_ff    <= '0;
               st_ff    <= ST_OK;
            end
         end
         S_CHECK: begin
            if (is_bus && outside) begin
               st_ff <= ST_OUTSIDE;
            end
            ofs_ff <= addr_ff - base_ff;
         end
         S_DECODE: begin
            if (is_bus) begin
               case (dec_cls)
                  RC_DOMAIN: begin
                     if (kind_ff == KIND_READ) begin
                        rd_ff <= 32'(domain_en_ff) << DOMAIN_IE_BIT;
                     end
                  end
                  RC_CLAIM: begin
                     if (kind_ff == KIND_WRITE) begin
                        st_ff <= ST_CLAIM_WRITE;
                     end
                  end
                  RC_UNKNOWN: begin
                     st_ff <= ST_UNKNOWN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_MEM: begin
            if (kind_ff == KIND_READ) begin
               rd_ff <= ram_rdata;
            end
         end
         S_SCAN: begin
            if (scan_res.done) begin
               if (scan_res.found) begin
                  rd_ff <= 32'(scan_id) << CLAIM_ID_SHIFT;
               end else begin
                  st_ff <= ST_CLAIM_NONE;
               end
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_rd_ff  <= rd_ff;
               rsp_st_ff  <= st_ff;
               rsp_irq_ff <= domain_en_ff && (|pending_ff);
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_irq_ff, rsp_st_ff, rsp_rd_ff};

endmodule

// ===== tb/sv/interrupt_source_controller_tb.sv =====
// ----------------------------------------------------------------------------
// interrupt_source_controller_tb
// Drives bus reads, bus writes and wire events into the interrupt source
// controller and checks every response against an in-bench prediction of
// the domain state: source configuration words, enable and pending bits,
// domain enable and the register window.
// ----------------------------------------------------------------------------
module interrupt_source_controller_tb
   import isc_pkg::*;
();

   localparam int NUM_SRC  = DEF_NUM_SOURCES;
   localparam int NUM_HART = DEF_NUM_HARTS;
   localparam logic [31:0] SRCCFG_LAST = OFS_SRCCFG_FIRST + 32'((NUM_SRC - 1) * 4);
   localparam logic [31:0] TARGET_LAST = OFS_TARGET_FIRST + 32'((NUM_SRC - 1) * 4);
   localparam logic [31:0] HART_END    = OFS_HART_BASE + 32'(NUM_HART * HART_STRIDE);
   localparam logic [31:0] CFG_EDGE_RISE = 32'(SRC_MODE_EDGE_RISE);
   // mode field and delegate bit, overwritten to set up an active rising-edge source
   localparam logic [31:0] CFG_MODE_MASK =
      32'((1 << SRC_MODE_W) - 1) | (32'h1 << SRC_DELEGATE_BIT);
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 16;
   localparam int MAX_REPORTS     = 100;
   localparam int PHASE_ITEMS     = 360;

   typedef struct packed {
      logic [31:0] read_data;
      status_type  status;
      logic        irq_pending;
   } bus_result_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   // predicted domain state
   logic [31:0]        win_base_m = '0;
   logic [15:0]        win_size_m = WINDOW_SIZE_RESET;
   logic [31:0]        src_cfg_m [NUM_SRC];
   logic [NUM_SRC-1:0] pend_m     = '0;
   logic [NUM_SRC-1:0] en_m       = '0;
   logic               dom_en_m   = 1'b0;

   bus_result_type results_due[$];
   int          mismatch_count = 0;
   int          burst_left     = 0;

   // receiver stall pattern
   int          hold_token   = 0;
   int          hold_seen    = 0;
   int          hold_left    = 0;
   int          pattern_left = 0;
   logic [31:0] stall_mask   = '0;
   logic        free_run     = 1'b1;

   interrupt_source_controller dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic bus_result_type domain_step(kind_type kind, logic [31:0] addr,
         logic [3:0] nbytes, logic [31:0] wd, logic [5:0] src, logic lvl);
      bus_result_type res;
      logic [32:0] acc_end;
      logic [32:0] win_end;
      logic [31:0] ofs;
      logic [31:0] cfg;
      logic        wr;
      int          idx;
      int          k;
      res.read_data = '0;
      res.status    = ST_OK;
      wr      = (kind == KIND_WRITE);
      acc_end = {1'b0, addr} + 33'(nbytes);
      win_end = {1'b0, win_base_m} + 33'(win_size_m);
      ofs     = addr - win_base_m;
      if (kind == KIND_READ || kind == KIND_WRITE) begin
         if (addr < win_base_m || acc_end > win_end) begin
            res.status = ST_OUTSIDE;
         end else if (ofs >= OFS_SRCCFG_FIRST && ofs <= SRCCFG_LAST) begin
            idx = int'((ofs - OFS_SRCCFG_FIRST) >> 2);
            if (wr) src_cfg_m[idx] = wd;
            else res.read_data = src_cfg_m[idx];
         end else if (ofs >= OFS_TARGET_FIRST && ofs <= TARGET_LAST) begin
            // target window reads as zero
         end else if (ofs >= OFS_HART_BASE && ofs < HART_END) begin
            case (ofs[HART_REG_W-1:0])
               HART_OFS_IDELIVERY, HART_OFS_IFORCE, HART_OFS_ITHRESHOLD,
               HART_OFS_TOPI: begin
               end
               HART_OFS_CLAIMI: begin
                  if (wr) begin
                     res.status = ST_CLAIM_WRITE;
                  end else begin
                     // lowest pending source wins, enables play no part
                     res.status = ST_CLAIM_NONE;
                     for (k = 0; k < NUM_SRC; k++) begin
                        if (pend_m[k] && res.status == ST_CLAIM_NONE) begin
                           pend_m[k]     = 1'b0;
                           res.read_data = 32'(k + 1) << CLAIM_ID_SHIFT;
                           res.status    = ST_OK;
                        end
                     end
                  end
               end
               default: res.status = ST_UNKNOWN;
            endcase
         end else if (ofs == OFS_DOMAINCFG) begin
            if (wr) dom_en_m = wd[DOMAIN_IE_BIT];
            else res.read_data[DOMAIN_IE_BIT] = dom_en_m;
         end else if (ofs == OFS_SET_ENABLE || ofs == OFS_CLR_ENABLE) begin
            if (wr && wd >= 1 && wd <= NUM_SRC) en_m[wd-1] = (ofs == OFS_SET_ENABLE);
         end else begin
            res.status = ST_UNKNOWN;
         end
      end else if (kind == KIND_EVENT && dom_en_m && src >= 1 && src <= NUM_SRC) begin
         cfg = src_cfg_m[src-1];
         if (!cfg[SRC_DELEGATE_BIT] && cfg[SRC_MODE_W-1:0] == SRC_MODE_EDGE_RISE)
            pend_m[src-1] = lvl;
      end
      res.irq_pending = dom_en_m && (|pend_m);
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t: %s mismatch, got 0x%0h, want 0x%0h", $time, what, got, want);
   endtask

   task automatic check_response(logic [RSP_TDATA_W-1:0] got);
      bus_result_type want;
      if (results_due.size() == 0) begin
         report_mismatch("response with none outstanding", got[31:0], '0);
      end else begin
         want = results_due.pop_front();
         if (got[31:0] !== want.read_data)
            report_mismatch("read_data", got[31:0], want.read_data);
         if (got[34:32] !== want.status)
            report_mismatch("status", 32'(got[34:32]), 32'(want.status));
         if (got[35] !== want.irq_pending)
            report_mismatch("irq_pending", 32'(got[35]), 32'(want.irq_pending));
      end
   endtask

   // response side: check each transfer, stall on a rotating random mask
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_response(rsp_tdata);
      if (hold_token != hold_seen) begin
         hold_seen = hold_token;
         hold_left = HOLD_OFF_CYCLES;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            stall_mask   = $urandom;
            pattern_left = $urandom_range(32, 200);
            free_run     = ($urandom_range(0, 3) == 0);
         end
         pattern_left--;
         stall_mask = {stall_mask[0], stall_mask[31:1]};
         rsp_tready <= free_run || stall_mask[0] || stall_mask[7];
      end
   end

   task automatic send_req(kind_type kind, logic [31:0] addr, logic [3:0] nbytes,
         logic [31:0] wd, logic [5:0] src, logic lvl);
      if (burst_left <= 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {5'b0, lvl, src, wd, nbytes, addr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      results_due.push_back(domain_step(kind, addr, nbytes, wd, src, lvl));
   endtask

   task automatic bus_op(kind_type kind, logic [31:0] ofs, logic [31:0] wd,
         logic [3:0] nbytes = 4'd4);
      send_req(kind, win_base_m + ofs, nbytes, wd, 6'($urandom), 1'($urandom));
   endtask

   task automatic wire_event(logic [5:0] src, logic lvl);
      send_req(KIND_EVENT, $urandom, 4'($urandom), $urandom, src, lvl);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic configure_window(logic [31:0] base, logic [15:0] span);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= CSR_WINDOW_BASE;
      csr_wdata <= base;
      @(posedge clock);
      csr_index <= CSR_WINDOW_SIZE;
      csr_wdata <= 32'(span);
      @(posedge clock);
      csr_we <= 1'b0;
      win_base_m = base;
      win_size_m = span;
   endtask

   function automatic logic [31:0] claim_ofs(int hart);
      return OFS_HART_BASE + 32'(hart * HART_STRIDE) + 32'(HART_OFS_CLAIMI);
   endfunction

   function automatic logic [5:0] hot_source();
      case ($urandom_range(0, 4))
         0, 1: return 6'($urandom_range(1, 6));
         2: return 6'($urandom_range(58, 63));
         default: return 6'($urandom);
      endcase
   endfunction

   function automatic logic [3:0] rand_size();
      int r;
      r = $urandom_range(0, 19);
      if (r < 14) return 4'd4;
      if (r < 19) return 4'($urandom_range(1, 8));
      return 4'($urandom);
   endfunction

   // mostly the configure, enable, event, claim flow, with some noise
   task automatic random_item();
      int          pick;
      logic [31:0] data;
      logic [5:0]  src;
      kind_type    rw;
      pick = $urandom_range(0, 99);
      src  = hot_source();
      rw   = kind_type'($urandom_range(0, 1));
      if (src == 0 && pick >= 30) src = 6'd1;
      if (pick < 30) begin
         wire_event(src, $urandom_range(0, 4) < 3);
      end else if (pick < 45) begin
         bus_op(KIND_READ, claim_ofs($urandom_range(0, NUM_HART - 1)), $urandom, rand_size());
      end else if (pick < 58) begin
         data = ($urandom & ~CFG_MODE_MASK) | CFG_EDGE_RISE;
         bus_op(KIND_WRITE, OFS_SRCCFG_FIRST + 32'(4 * (src - 1)) + 32'($urandom_range(0, 3)),
                data, rand_size());
      end else if (pick < 63) begin
         bus_op(KIND_READ, OFS_SRCCFG_FIRST + 32'(4 * (src - 1)), $urandom, rand_size());
      end else if (pick < 71) begin
         data = ($urandom_range(0, 9) < 8) ? 32'(hot_source()) : $urandom;
         bus_op(KIND_WRITE, ($urandom_range(0, 1) == 0) ? OFS_SET_ENABLE : OFS_CLR_ENABLE,
                data, rand_size());
      end else if (pick < 77) begin
         data = $urandom;
         if ($urandom_range(0, 9) < 8) data[DOMAIN_IE_BIT] = 1'b1;
         bus_op(KIND_WRITE, OFS_DOMAINCFG, data, rand_size());
      end else if (pick < 80) begin
         bus_op(KIND_READ, OFS_DOMAINCFG, $urandom, rand_size());
      end else if (pick < 87) begin
         case ($urandom_range(0, 3))
            0: bus_op(rw, OFS_TARGET_FIRST + 32'($urandom_range(0, (NUM_SRC - 1) * 4 + 3)),
                      $urandom, rand_size());
            1: bus_op(KIND_READ,
                      OFS_HART_BASE + 32'($urandom_range(0, NUM_HART * HART_STRIDE - 1)),
                      $urandom, rand_size());
            2: bus_op(KIND_WRITE, claim_ofs($urandom_range(0, NUM_HART - 1)), $urandom);
            default: bus_op(KIND_WRITE,
                            OFS_HART_BASE + 32'($urandom_range(0, NUM_HART * HART_STRIDE - 1)),
                            $urandom, rand_size());
         endcase
      end else if (pick < 94) begin
         case ($urandom_range(0, 2))
            0: bus_op(rw, 32'($urandom_range(0, 16'hFFFF)), $urandom, rand_size());
            1: send_req(rw, $urandom, rand_size(), $urandom, 6'($urandom), 1'($urandom));
            default: send_req(KIND_NONE, $urandom, 4'($urandom), $urandom, 6'($urandom),
                              1'($urandom));
         endcase
      end else begin
         // arbitrary words, mostly leaving the source inactive
         bus_op(KIND_WRITE, OFS_SRCCFG_FIRST + 32'(4 * (src - 1)), $urandom, rand_size());
      end
   endtask

   task automatic test_register_access();
      bus_op(KIND_READ, OFS_DOMAINCFG, $urandom);
      bus_op(KIND_WRITE, OFS_DOMAINCFG, 32'hFFFF_FFFF);
      bus_op(KIND_READ, OFS_DOMAINCFG, $urandom);
      bus_op(KIND_WRITE, OFS_SRCCFG_FIRST, CFG_EDGE_RISE);
      bus_op(KIND_WRITE, SRCCFG_LAST, 32'hFFFF_FFFF);
      bus_op(KIND_READ, OFS_SRCCFG_FIRST + 32'd3, $urandom, 4'd1);
      bus_op(KIND_READ, SRCCFG_LAST + 32'd1, $urandom);
      bus_op(KIND_WRITE, OFS_SET_ENABLE, 32'd1);
      bus_op(KIND_WRITE, OFS_SET_ENABLE, 32'(NUM_SRC));
      bus_op(KIND_WRITE, OFS_SET_ENABLE, 32'd0);
      bus_op(KIND_WRITE, OFS_CLR_ENABLE, 32'(NUM_SRC + 1));
      bus_op(KIND_READ, OFS_CLR_ENABLE, $urandom);
      bus_op(KIND_WRITE, TARGET_LAST, $urandom);
      bus_op(KIND_READ, OFS_TARGET_FIRST, $urandom);
      bus_op(KIND_READ, OFS_HART_BASE + 32'(HART_OFS_TOPI), $urandom);
      bus_op(KIND_READ, OFS_HART_BASE + 32'h10, $urandom);
      bus_op(KIND_READ, 32'h2000, $urandom, 4'd0);
      bus_op(KIND_READ, 32'h1, $urandom, 4'd15);
      send_req(KIND_NONE, 32'hFFFF_FFFF, 4'hF, 32'hFFFF_FFFF, 6'h3F, 1'b1);
   endtask

   task automatic test_events_and_claims();
      wire_event(6'd1, 1'b1);
      wire_event(6'd0, 1'b1);
      // source 63 is delegated at this point
      wire_event(6'd63, 1'b1);
      bus_op(KIND_WRITE, SRCCFG_LAST, CFG_EDGE_RISE);
      wire_event(6'd63, 1'b1);
      bus_op(KIND_READ, claim_ofs(NUM_HART - 1), $urandom);
      bus_op(KIND_WRITE, claim_ofs(0), $urandom);
      wire_event(6'd63, 1'b0);
      bus_op(KIND_READ, claim_ofs(0), $urandom);
      // claim still works with the domain switched off
      wire_event(6'd1, 1'b1);
      bus_op(KIND_WRITE, OFS_DOMAINCFG, 32'h0);
      wire_event(6'd63, 1'b1);
      bus_op(KIND_READ, claim_ofs(1), $urandom);
   endtask

   task automatic window_edge_phase(logic [31:0] base, logic [15:0] span);
      configure_window(base, span);
      send_req(KIND_READ, base - 32'd1, 4'd1, $urandom, 6'($urandom), 1'($urandom));
      send_req(KIND_WRITE, base + 32'(span) - 32'd4, 4'd4, $urandom, 6'($urandom),
               1'($urandom));
      send_req(KIND_READ, base + 32'(span) - 32'd3, 4'd4, $urandom, 6'($urandom),
               1'($urandom));
      repeat (20) random_item();
   endtask

   task automatic test_window_edges();
      window_edge_phase(32'h0000_0000, 16'h0000);
      window_edge_phase(32'hFFFF_FFFF, 16'hFFFF);
      window_edge_phase(32'hFFFF_0000, 16'hFFFF);
      window_edge_phase(32'hFFFF_8000, 16'h8000);
      window_edge_phase(32'h0000_1000, 16'h0010);
   endtask

   task automatic test_backpressure();
      configure_window(32'h0, WINDOW_SIZE_RESET);
      hold_token++;
      burst_left = 1000;
      repeat (40) random_item();
      burst_left = 0;
   endtask

   task automatic test_random_traffic();
      int phase;
      for (phase = 0; phase < 5; phase++) begin
         case (phase)
            0: configure_window(32'h0, 16'hFFFF);
            1: configure_window(32'h4000_0000, WINDOW_SIZE_RESET);
            2: configure_window(32'($urandom_range(0, 16'hFFFE)) << 16,
                                16'($urandom_range(16'h4100, 16'hFFFF)));
            3: configure_window(32'hFFFF_0000, 16'hFFFF);
            default: configure_window(32'h0, WINDOW_SIZE_RESET);
         endcase
         repeat (PHASE_ITEMS) random_item();
      end
   endtask

   initial begin
      int n;
      for (n = 0; n < NUM_SRC; n++) src_cfg_m[n] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_register_access();
      test_events_and_claims();
      test_window_edges();
      test_backpressure();
      test_random_traffic();
      wait_idle();
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
